### hdl/lsdr_pkg.sv
// ----------------------------------------------------------------------------
// lsdr_pkg
// Shared types and constants for the LED sparkle, decay and rotate block.
// ----------------------------------------------------------------------------
package lsdr_pkg;

    // One request on the input channel.
    typedef struct packed {
        logic        action;
        logic [31:0] cycle_number;
        logic [15:0] spawn_random;
        logic [15:0] place_random;
        logic [15:0] flash_random;
        logic [15:0] read_index;
    } item_t;

    // One result on the result channel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green_level;
        logic [7:0] blue;
    } result_t;

    // Action codes.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PIXELS_IN_USE  = 3'd0;
    localparam logic [2:0] CFG_FLASH_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_SPAWN_PERIOD   = 3'd2;
    localparam logic [2:0] CFG_DECAY_FRACTION = 3'd3;
    localparam logic [2:0] CFG_SHIFT_PERIOD   = 3'd4;

    // Configuration reset values.
    localparam logic [8:0]  RST_PIXELS_IN_USE  = 9'd256;
    localparam logic [15:0] RST_FLASH_PERIOD   = 16'd125;
    localparam logic [15:0] RST_SPAWN_PERIOD   = 16'd10;
    localparam logic [15:0] RST_DECAY_FRACTION = 16'd62259;
    localparam logic [15:0] RST_SHIFT_PERIOD   = 16'd30;

    // Fixed colours, red in the top byte.
    localparam logic [23:0] GREEN_PIXEL  = 24'h00FF00;
    localparam logic [23:0] YELLOW_PIXEL = 24'hFFFF00;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST,
        ST_POS,
        ST_START,
        ST_SPAWN,
        ST_WALK,
        ST_SHIFT,
        ST_FETCH,
        ST_DELIVER
    } state_t;

    // Source of the data written into the pixel store.
    typedef enum logic [1:0] {
        WR_ZERO,
        WR_GREEN,
        WR_DECAY
    } wr_mode_t;

    // Control from the sequencer to the pixel store.
    typedef struct packed {
        logic     rd_en;
        logic     wr_en;
        wr_mode_t wr_mode;
    } store_ctrl_t;

endpackage

### hdl/lsdr_rem_unit.sv
// ----------------------------------------------------------------------------
// lsdr_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle, 16 or 32.
// ----------------------------------------------------------------------------
module lsdr_rem_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        short_op,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [15:0] remainder
);
    import lsdr_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] num_reg;
    logic [15:0] div_reg;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [16:0] trial;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        trial = {rem_reg, num_reg[31]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = 16'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= short_op ? 5'd15 : 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= short_op ? {dividend[15:0], 16'h0000} : dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hdl/lsdr_pixel_store.sv
// ----------------------------------------------------------------------------
// lsdr_pixel_store
// Pixel memory with a registered read port and the per-channel decay datapath.
// ----------------------------------------------------------------------------
module lsdr_pixel_store #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                          aclk,
    input  lsdr_pkg::store_ctrl_t         ctrl,
    input  logic [$clog2(MAX_PIXELS)-1:0] rd_addr,
    input  logic [$clog2(MAX_PIXELS)-1:0] wr_addr,
    input  logic [15:0]                   decay_fraction,
    output logic [23:0]                   rd_data
);
    import lsdr_pkg::*;

    logic [23:0] mem [MAX_PIXELS];
    logic [23:0] q_reg;
    logic [23:0] wr_data;
    logic [23:0] red_prod;
    logic [23:0] green_prod;
    logic [23:0] blue_prod;

    // Each channel is scaled by the 0.16 fraction and truncated.
    assign red_prod   = 24'(q_reg[23:16]) * 24'(decay_fraction);
    assign green_prod = 24'(q_reg[15:8])  * 24'(decay_fraction);
    assign blue_prod  = 24'(q_reg[7:0])   * 24'(decay_fraction);

    always_comb begin
        unique case (ctrl.wr_mode)
            WR_ZERO:  wr_data = '0;
            WR_GREEN: wr_data = GREEN_PIXEL;
            WR_DECAY: wr_data = {red_prod[23:16], green_prod[23:16], blue_prod[23:16]};
            default:  wr_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

### hdl/led_sparkle_decay_rotate.sv
// ----------------------------------------------------------------------------
// led_sparkle_decay_rotate
// Ring of RGB pixels with random green sparkles, decay and slow rotation.
// ----------------------------------------------------------------------------
// After reset the block clears all MAX_PIXELS pixels of the memory to black
// and accepts no request until that pass is over; configuration writes are
// taken at any time. Every remainder the block needs goes through one
// bit-serial remainder unit, for a 16-bit operand or for the 32-bit cycle
// number, and this unit sets the pace. A read request that flashes yellow
// skips the position and start offset steps, and a read request can be held
// back by a full result register. A tick request writes a green pixel first
// when it spawns one, then its decay pass walks the memory one pixel a cycle
// through its single read and single write port. The result channel has its
// own output register, so a new request may be accepted while an earlier
// result still waits there.
module led_sparkle_decay_rotate #(
    parameter int MAX_PIXELS = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lsdr_pkg::item_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lsdr_pkg::result_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import lsdr_pkg::*;

    // Index width of the pixel memory, and a count width that reaches the depth.
    localparam int IW = $clog2(MAX_PIXELS);
    localparam int CW = $clog2(MAX_PIXELS + 1);

    // Configuration registers.
    logic [8:0]  pixels_in_use_reg;
    logic [15:0] flash_period_reg;
    logic [15:0] spawn_period_reg;
    logic [15:0] decay_fraction_reg;
    logic [15:0] shift_period_reg;

    // Sequencer and working registers.
    state_t      state_reg;
    state_t      state_next;
    item_t       item_reg;
    logic        hit_reg;
    logic        pending_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] rs_reg;
    logic [IW-1:0] ring_start_reg;
    logic [CW-1:0] cnt_reg;
    logic        pipe_valid_reg;
    logic [IW-1:0] pipe_addr_reg;
    logic        m_valid_reg;
    result_t     out_reg;

    // Remainder unit hookup.
    logic        div_start;
    logic        div_short;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        rem_busy;
    logic        rem_done;
    logic [15:0] rem_value;
    logic        is_div_state;

    // Pixel store hookup.
    store_ctrl_t   store_ctrl;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [23:0]   rd_data;

    // Derived values.
    logic [CW-1:0] live_cnt;
    logic [15:0]   flash_div;
    logic [15:0]   spawn_div;
    logic [15:0]   shift_div;
    logic [IW:0]   slot_sum;
    logic [IW-1:0] slot;
    logic [IW:0]   rot_sum;
    logic [IW-1:0] rot_start;
    logic          accept;
    logic          deliver;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixels_in_use_reg  <= RST_PIXELS_IN_USE;
            flash_period_reg   <= RST_FLASH_PERIOD;
            spawn_period_reg   <= RST_SPAWN_PERIOD;
            decay_fraction_reg <= RST_DECAY_FRACTION;
            shift_period_reg   <= RST_SHIFT_PERIOD;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PIXELS_IN_USE:  pixels_in_use_reg  <= cfg_data[8:0];
                CFG_FLASH_PERIOD:   flash_period_reg   <= cfg_data;
                CFG_SPAWN_PERIOD:   spawn_period_reg   <= cfg_data;
                CFG_DECAY_FRACTION: decay_fraction_reg <= cfg_data;
                CFG_SHIFT_PERIOD:   shift_period_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A pixel count of zero behaves as one, and one above the memory depth is
    // clamped to the depth. A period of zero behaves as one.
    always_comb begin
        if (pixels_in_use_reg == '0) begin
            live_cnt = CW'(1);
        end else if (32'(pixels_in_use_reg) > MAX_PIXELS) begin
            live_cnt = CW'(MAX_PIXELS);
        end else begin
            live_cnt = CW'(pixels_in_use_reg);
        end
    end

    assign flash_div = (flash_period_reg == '0) ? 16'd1 : flash_period_reg;
    assign spawn_div = (spawn_period_reg == '0) ? 16'd1 : spawn_period_reg;
    assign shift_div = (shift_period_reg == '0) ? 16'd1 : shift_period_reg;

    // Both terms are already below the pixel count, so one conditional
    // subtraction wraps the sum back into the ring.
    assign slot_sum = {1'b0, pos_reg} + {1'b0, rs_reg};
    assign slot     = (slot_sum >= (IW+1)'(live_cnt))
                      ? IW'(slot_sum - (IW+1)'(live_cnt)) : slot_sum[IW-1:0];
    assign rot_sum   = {1'b0, rs_reg} + (IW+1)'(1);
    assign rot_start = (rot_sum >= (IW+1)'(live_cnt)) ? '0 : rot_sum[IW-1:0];

    // Operands for the remainder unit follow the current step of the sequence.
    // The period test comes first, then as needed the position and the start offset,
    // both taken modulo the pixel count, and for a tick the rotation test.
    assign is_div_state = (state_reg == ST_TEST) || (state_reg == ST_POS) ||
                          (state_reg == ST_START) || (state_reg == ST_SHIFT);
    assign div_start    = is_div_state && !pending_reg;

    always_comb begin
        div_short    = 1'b1;
        div_dividend = '0;
        div_divisor  = 16'd1;
        unique case (state_reg)
            ST_TEST: begin
                if (item_reg.action == ACT_READ) begin
                    div_dividend = 32'(item_reg.flash_random);
                    div_divisor  = flash_div;
                end else begin
                    div_dividend = 32'(item_reg.spawn_random);
                    div_divisor  = spawn_div;
                end
            end
            ST_POS: begin
                div_dividend = (item_reg.action == ACT_READ) ? 32'(item_reg.read_index)
                                                             : 32'(item_reg.place_random);
                div_divisor  = 16'(live_cnt);
            end
            ST_START: begin
                div_dividend = 32'(ring_start_reg);
                div_divisor  = 16'(live_cnt);
            end
            ST_SHIFT: begin
                div_short    = 1'b0;
                div_dividend = item_reg.cycle_number;
                div_divisor  = shift_div;
            end
            default: begin
            end
        endcase
    end

    lsdr_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .short_op  (div_short),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (rem_busy),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // The result register may be loaded when it is empty or being emptied.
    assign deliver = (state_reg == ST_DELIVER) && (!m_valid_reg || m_ready);

    // Next state and pixel store control.
    always_comb begin
        state_next         = state_reg;
        s_ready            = 1'b0;
        store_ctrl.rd_en   = 1'b0;
        store_ctrl.wr_en   = 1'b0;
        store_ctrl.wr_mode = WR_ZERO;
        rd_addr            = '0;
        wr_addr            = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                store_ctrl.wr_en = 1'b1;
                wr_addr          = cnt_reg[IW-1:0];
                if (cnt_reg == CW'(MAX_PIXELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (rem_done) begin
                    if (item_reg.action == ACT_READ) begin
                        state_next = (rem_value == '0) ? ST_DELIVER : ST_POS;
                    end else begin
                        state_next = (rem_value == '0) ? ST_POS : ST_START;
                    end
                end
            end
            ST_POS: begin
                if (rem_done) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (rem_done) begin
                    if (item_reg.action == ACT_READ) begin
                        state_next = ST_FETCH;
                    end else begin
                        state_next = hit_reg ? ST_SPAWN : ST_WALK;
                    end
                end
            end
            ST_SPAWN: begin
                store_ctrl.wr_en   = 1'b1;
                store_ctrl.wr_mode = WR_GREEN;
                wr_addr            = slot;
                state_next         = ST_WALK;
            end
            ST_WALK: begin
                // Read one pixel a cycle and write it back decayed in the next cycle.
                if (cnt_reg < live_cnt) begin
                    store_ctrl.rd_en = 1'b1;
                    rd_addr          = cnt_reg[IW-1:0];
                end
                if (pipe_valid_reg) begin
                    store_ctrl.wr_en   = 1'b1;
                    store_ctrl.wr_mode = WR_DECAY;
                    wr_addr            = pipe_addr_reg;
                end
                if ((cnt_reg == live_cnt) && !pipe_valid_reg) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (rem_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                store_ctrl.rd_en = 1'b1;
                rd_addr          = slot;
                state_next       = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (deliver) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers of the sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            pending_reg    <= 1'b0;
            pipe_valid_reg <= 1'b0;
            ring_start_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (div_start) begin
                pending_reg <= 1'b1;
            end else if (rem_done) begin
                pending_reg <= 1'b0;
            end

            if (state_reg == ST_CLEAR) begin
                cnt_reg <= (cnt_reg == CW'(MAX_PIXELS - 1)) ? '0 : cnt_reg + CW'(1);
            end else if ((state_reg == ST_START) && rem_done) begin
                cnt_reg <= '0;
            end else if ((state_reg == ST_WALK) && (cnt_reg < live_cnt)) begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            pipe_valid_reg <= (state_reg == ST_WALK) && (cnt_reg < live_cnt);

            if ((state_reg == ST_SHIFT) && rem_done && (rem_value == '0)) begin
                ring_start_reg <= rot_start;
            end

            if (deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_WALK) begin
            pipe_addr_reg <= cnt_reg[IW-1:0];
        end
        if ((state_reg == ST_TEST) && rem_done) begin
            hit_reg <= (rem_value == '0);
        end
        if ((state_reg == ST_POS) && rem_done) begin
            pos_reg <= rem_value[IW-1:0];
        end
        if ((state_reg == ST_START) && rem_done) begin
            rs_reg <= rem_value[IW-1:0];
        end
        if (deliver) begin
            out_reg <= hit_reg ? result_t'(YELLOW_PIXEL) : result_t'(rd_data);
        end
    end

    lsdr_pixel_store #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_store (
        .aclk           (aclk),
        .ctrl           (store_ctrl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .decay_fraction (decay_fraction_reg),
        .rd_data        (rd_data)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The remainder unit only finishes while the sequencer waits for it.
    a_done_in_div_state : assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> is_div_state)
        else $error("remainder finished outside a remainder step");

    // The pixel memory is written only while clearing, spawning or decaying.
    a_write_states : assert property (@(posedge aclk) disable iff (!aresetn)
        store_ctrl.wr_en |-> ((state_reg == ST_CLEAR) || (state_reg == ST_SPAWN) ||
                              (state_reg == ST_WALK)))
        else $error("pixel memory written outside a writing step");

    // A new request never meets a remainder still in progress.
    a_accept_unit_free : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!rem_busy && !pending_reg))
        else $error("request accepted while the remainder unit is busy");

    // A rotation leaves the start offset inside the ring.
    a_rotation_in_ring : assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SHIFT) && rem_done && (rem_value == '0))
            |=> (CW'(ring_start_reg) < live_cnt))
        else $error("start offset left the ring after rotation");

endmodule
